// ===== design/level_meter_ballistics_assert.svh =====
// assertion macros shared by the level meter ballistics rtl
`ifndef LEVEL_METER_BALLISTICS_ASSERT_SVH
`define LEVEL_METER_BALLISTICS_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LMB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("level meter ballistics: check failed");

// next-cycle implication, disabled during reset
`define LMB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("level meter ballistics: check failed");

`endif

// ===== design/lmb_pkg.sv =====
// shared types and constants for the level meter ballistics block
package lmb_pkg;

  localparam int LEVEL_W = 18;
  localparam int VAL_W   = 16;
  localparam int HOLD_W  = 8;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [VAL_W-1:0]  ATTACK_RST = 16'd52429;
  localparam logic [VAL_W-1:0]  DECAY_RST  = 16'd3277;
  localparam logic [VAL_W-1:0]  PDECAY_RST = 16'd62259;
  localparam logic [HOLD_W-1:0] HOLD_RST   = 8'd120;
  localparam logic [VAL_W-1:0]  THRESH_RST = 16'd66;

  typedef enum logic [2:0] {
    REG_ATTACK = 3'd0,
    REG_DECAY  = 3'd1,
    REG_PDECAY = 3'd2,
    REG_HOLD   = 3'd3,
    REG_THRESH = 3'd4
  } lmb_reg_t;

  typedef struct packed {
    logic [VAL_W-1:0]  attack_coeff;
    logic [VAL_W-1:0]  decay_coeff;
    logic [VAL_W-1:0]  peak_decay;
    logic [HOLD_W-1:0] hold_ticks;
    logic [VAL_W-1:0]  redraw_threshold;
  } lmb_cfg_t;

  typedef struct packed {
    logic [VAL_W-1:0] shown_level;
    logic [VAL_W-1:0] peak_out;
    logic             redraw;
  } lmb_res_t;

endpackage

// ===== design/lmb_core.sv =====
// meter state and per-tick smoothing, peak hold and redraw logic
`include "level_meter_ballistics_assert.svh"

module lmb_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic signed [lmb_pkg::LEVEL_W-1:0] level,
  input  lmb_pkg::lmb_cfg_t            cfg,
  output lmb_pkg::lmb_res_t            res
);
  import lmb_pkg::*;

  logic [VAL_W-1:0]        smoothed_r, smoothed_nxt;
  logic [VAL_W-1:0]        held_peak_r, held_peak_nxt;
  logic [HOLD_W-1:0]       hold_left_r, hold_left_nxt;

  logic [VAL_W-1:0]        target;
  logic signed [VAL_W:0]   diff;
  logic [VAL_W-1:0]        coef;
  logic signed [2*VAL_W+1:0] prod;
  logic signed [2*VAL_W+1:0] prod_rnd;
  logic signed [VAL_W+1:0] step_amt;
  logic signed [VAL_W+2:0] sum;
  logic [2*VAL_W-1:0]      decay_prod;
  logic                    new_max;
  logic [VAL_W-1:0]        gap;

  // saturate the raw level to 0..full scale
  always_comb begin
    if (level[LEVEL_W-1]) begin
      target = '0;
    end else if (|level[LEVEL_W-2:VAL_W]) begin
      target = '1;
    end else begin
      target = level[VAL_W-1:0];
    end
  end

  assign diff     = $signed({1'b0, target}) - $signed({1'b0, smoothed_r});
  assign coef     = (target > smoothed_r) ? cfg.attack_coeff : cfg.decay_coeff;
  assign prod     = (2*VAL_W+2)'(diff) * (2*VAL_W+2)'($signed({1'b0, coef}));
  assign prod_rnd = prod + (2*VAL_W+2)'(33'sd32768);
  // arithmetic shift by 16, floor rounding
  assign step_amt = prod_rnd[2*VAL_W+1:VAL_W];
  assign sum      = $signed({3'b000, smoothed_r}) + (VAL_W+3)'(step_amt);

  always_comb begin
    if (sum < 0) begin
      smoothed_nxt = '0;
    end else if (|sum[VAL_W+2:VAL_W]) begin
      smoothed_nxt = '1;
    end else begin
      smoothed_nxt = sum[VAL_W-1:0];
    end
  end

  assign decay_prod = held_peak_r * cfg.peak_decay;
  assign new_max    = smoothed_nxt > held_peak_r;

  always_comb begin
    held_peak_nxt = held_peak_r;
    hold_left_nxt = hold_left_r;
    priority if (new_max) begin
      held_peak_nxt = smoothed_nxt;
      hold_left_nxt = cfg.hold_ticks;
    end else if (hold_left_r != '0) begin
      hold_left_nxt = hold_left_r - 1'b1;
    end else begin
      held_peak_nxt = decay_prod[2*VAL_W-1:VAL_W];
    end
  end

  assign gap = (smoothed_nxt >= target) ? (smoothed_nxt - target) : (target - smoothed_nxt);

  assign res.shown_level = smoothed_nxt;
  assign res.peak_out    = held_peak_nxt;
  assign res.redraw      = (gap > cfg.redraw_threshold) ||
                           (held_peak_nxt > cfg.redraw_threshold);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smoothed_r  <= '0;
      held_peak_r <= '0;
      hold_left_r <= '0;
    end else if (step) begin
      smoothed_r  <= smoothed_nxt;
      held_peak_r <= held_peak_nxt;
      hold_left_r <= hold_left_nxt;
    end
  end

  `LMB_ASSERT_NXT(a_new_max_takes_level, clk, rst_n, step && new_max,
                  held_peak_r == smoothed_r)
  `LMB_ASSERT_NXT(a_hold_counts_down, clk, rst_n, step && !new_max && (hold_left_r != '0),
                  (hold_left_r == $past(hold_left_r) - 1'b1) && $stable(held_peak_r))
  `LMB_ASSERT_NXT(a_state_idle_holds, clk, rst_n, !step,
                  $stable(smoothed_r) && $stable(held_peak_r) && $stable(hold_left_r))

endmodule

// ===== design/level_meter_ballistics.sv =====
// top level: handshake registers, config registers and the meter core
//
//  port group  | direction | handshake           | payload
//  in_         | input     | in_valid/in_ready   | in_level_in
//  out_        | output    | out_valid/out_ready | out_shown_level, out_peak_out, out_redraw
//  cfg_        | input     | apb, pready tied hi | cfg_paddr, cfg_pwdata, cfg_prdata
//
// one tick per cycle sustained while out_ready is held high; from input transaction to
// result transaction a tick passes the input register, then the result register
// the core's state update and both multiplies sit between those two registers
// reset is synchronous, active low, and restores state and registers at once
// a stalled result holds its register; input keeps flowing until both stages are full
`include "level_meter_ballistics_assert.svh"

module level_meter_ballistics (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [lmb_pkg::LEVEL_W-1:0] in_level_in,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [lmb_pkg::VAL_W-1:0]         out_shown_level,
  output logic [lmb_pkg::VAL_W-1:0]         out_peak_out,
  output logic                              out_redraw,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lmb_pkg::ADDR_W-1:0]        cfg_paddr,
  input  logic [lmb_pkg::DATA_W-1:0]        cfg_pwdata,
  output logic [lmb_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                              cfg_pready
);
  import lmb_pkg::*;

  lmb_cfg_t                   cfg_r;
  logic                       in_valid_r;
  logic signed [LEVEL_W-1:0]  level_r;
  logic                       out_valid_r;
  lmb_res_t                   res_r;
  lmb_res_t                   core_res;
  logic                       adv;
  logic                       cfg_wr;
  logic [2:0]                 reg_idx;

  assign adv      = in_valid_r && (!out_valid_r || out_ready);
  // no input transaction while reset is applied
  assign in_ready = rst_n && (!in_valid_r || adv);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      level_r <= in_level_in;
    end
  end

  lmb_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .level (level_r),
    .cfg   (cfg_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= core_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_shown_level = res_r.shown_level;
  assign out_peak_out    = res_r.peak_out;
  assign out_redraw      = res_r.redraw;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_idx    = cfg_paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_coeff     <= ATTACK_RST;
      cfg_r.decay_coeff      <= DECAY_RST;
      cfg_r.peak_decay       <= PDECAY_RST;
      cfg_r.hold_ticks       <= HOLD_RST;
      cfg_r.redraw_threshold <= THRESH_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ATTACK: cfg_r.attack_coeff     <= cfg_pwdata[VAL_W-1:0];
        REG_DECAY:  cfg_r.decay_coeff      <= cfg_pwdata[VAL_W-1:0];
        REG_PDECAY: cfg_r.peak_decay       <= cfg_pwdata[VAL_W-1:0];
        REG_HOLD:   cfg_r.hold_ticks       <= cfg_pwdata[HOLD_W-1:0];
        REG_THRESH: cfg_r.redraw_threshold <= cfg_pwdata[VAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK: cfg_prdata = DATA_W'(cfg_r.attack_coeff);
      REG_DECAY:  cfg_prdata = DATA_W'(cfg_r.decay_coeff);
      REG_PDECAY: cfg_prdata = DATA_W'(cfg_r.peak_decay);
      REG_HOLD:   cfg_prdata = DATA_W'(cfg_r.hold_ticks);
      REG_THRESH: cfg_prdata = DATA_W'(cfg_r.redraw_threshold);
      default:    cfg_prdata = '0;
    endcase
  end

  `LMB_ASSERT_IMP(a_stall_only_when_full, clk, rst_n, !in_ready,
                  in_valid_r && out_valid_r && !out_ready)
  `LMB_ASSERT_NXT(a_advance_fills_output, clk, rst_n, adv, out_valid_r)
  `LMB_ASSERT_NXT(a_pending_tick_kept, clk, rst_n, in_valid_r && !adv,
                  in_valid_r && $stable(level_r))

endmodule

// ===== verif/testbench.sv =====
// self-checking testbench for the level meter ballistics block
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import lmb_pkg::*;

  localparam int RESET_CYCLES  = 5;
  localparam int NUM_REGS      = 5;
  localparam int REG_STRIDE    = 4;
  localparam int MAP_SLOTS     = (1 << ADDR_W) / REG_STRIDE;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 195;
  localparam int TAIL_CYCLES   = 8;
  localparam int STALL_LIMIT   = 1000;
  localparam int FULL_SCALE    = 65535;

  logic                       clk         = 1'b0;
  logic                       rst_n       = 1'b0;
  logic                       in_valid    = 1'b0;
  logic                       in_ready;
  logic signed [LEVEL_W-1:0]  in_level_in = '0;
  logic                       out_valid;
  logic                       out_ready   = 1'b0;
  logic [VAL_W-1:0]           out_shown_level;
  logic [VAL_W-1:0]           out_peak_out;
  logic                       out_redraw;
  logic                       cfg_psel    = 1'b0;
  logic                       cfg_penable = 1'b0;
  logic                       cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0]          cfg_paddr   = '0;
  logic [DATA_W-1:0]          cfg_pwdata  = '0;
  logic [DATA_W-1:0]          cfg_prdata;
  logic                       cfg_pready;

  level_meter_ballistics i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_level_in     (in_level_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_shown_level (out_shown_level),
    .out_peak_out    (out_peak_out),
    .out_redraw      (out_redraw),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // meter state and register copy, as after reset
  lmb_cfg_t         cfg_m   = '{16'd52429, 16'd3277, 16'd62259, 8'd120, 16'd66};
  logic [VAL_W-1:0]  level_q = '0;
  logic [VAL_W-1:0]  peak_q  = '0;
  logic [HOLD_W-1:0] hold_q  = '0;

  lmb_res_t expected_ticks[$];

  int fail_count    = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int settings_used = 0;
  int burst_left    = 0;
  int tx_gap_max    = 0;
  int rx_stall_max  = 0;
  int rx_count      = 0;

  // one meter tick: saturate, smooth, track the peak, decide on redraw
  function automatic lmb_res_t meter_tick(input logic signed [LEVEL_W-1:0] lvl);
    int       target;
    int       coef;
    int       nxt;
    int       gap_abs;
    longint   delta;
    lmb_res_t r;
    if (lvl < 0) target = 0;
    else if (lvl > FULL_SCALE) target = FULL_SCALE;
    else target = int'(lvl);
    coef = (target > int'(level_q)) ? int'(cfg_m.attack_coeff) : int'(cfg_m.decay_coeff);
    // rounded, floor toward minus infinity
    delta = (longint'(target - int'(level_q)) * coef + 32768) >>> 16;
    nxt = int'(level_q) + int'(delta);
    if (nxt < 0) nxt = 0;
    if (nxt > FULL_SCALE) nxt = FULL_SCALE;
    level_q = 16'(nxt);
    if (level_q > peak_q) begin
      peak_q = level_q;
      hold_q = cfg_m.hold_ticks;
    end else if (hold_q != 0) begin
      hold_q = hold_q - 1'b1;
    end else begin
      peak_q = 16'((32'(peak_q) * 32'(cfg_m.peak_decay)) >> 16);
    end
    gap_abs = nxt - target;
    if (gap_abs < 0) gap_abs = -gap_abs;
    r.shown_level = level_q;
    r.peak_out    = peak_q;
    r.redraw      = (gap_abs > int'(cfg_m.redraw_threshold)) ||
                    (peak_q > cfg_m.redraw_threshold);
    return r;
  endfunction

  task automatic send_level(input logic signed [LEVEL_W-1:0] lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      gap = (tx_gap_max == 0) ? 0 : $urandom_range(1, tx_gap_max);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid    <= 1'b1;
    in_level_in <= lvl;
    do @(posedge clk); while (!in_ready);
    expected_ticks.push_back(meter_tick(lvl));
    items_sent++;
  endtask

  task automatic wait_for_results();
    if (in_valid) in_valid <= 1'b0;
    burst_left = 0;
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic read_check(input lmb_reg_t r);
    logic [DATA_W-1:0] want;
    case (r)
      REG_ATTACK: want = DATA_W'(cfg_m.attack_coeff);
      REG_DECAY:  want = DATA_W'(cfg_m.decay_coeff);
      REG_PDECAY: want = DATA_W'(cfg_m.peak_decay);
      REG_HOLD:   want = DATA_W'(cfg_m.hold_ticks);
      default:    want = DATA_W'(cfg_m.redraw_threshold);
    endcase
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_W'(r * REG_STRIDE);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $error("prdata of %s: expected %0d, got %0d", r.name(), want, cfg_prdata);
      fail_count++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // junk above the register width must be dropped by the block
  task automatic write_reg(input int idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] word;
    int                w;
    w    = (idx == REG_HOLD) ? HOLD_W : VAL_W;
    word = value | ($urandom() << w);
    case (idx)
      REG_ATTACK: cfg_m.attack_coeff     = word[VAL_W-1:0];
      REG_DECAY:  cfg_m.decay_coeff      = word[VAL_W-1:0];
      REG_PDECAY: cfg_m.peak_decay       = word[VAL_W-1:0];
      REG_HOLD:   cfg_m.hold_ticks       = word[HOLD_W-1:0];
      REG_THRESH: cfg_m.redraw_threshold = word[VAL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(idx * REG_STRIDE);
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx < NUM_REGS) read_check(lmb_reg_t'(idx));
  endtask

  task automatic test_register_access();
    for (int i = 0; i < NUM_REGS; i++) read_check(lmb_reg_t'(i));
    // unmapped slots must leave every register alone
    for (int i = NUM_REGS; i < MAP_SLOTS; i++) write_reg(i, $urandom());
    for (int i = 0; i < NUM_REGS; i++) read_check(lmb_reg_t'(i));
  endtask

  task automatic test_input_extremes();
    int levels[] = '{0, 131071, 65536, 65535, -1, -131072, 1, 32768, -65537};
    settings_used++;
    foreach (levels[i]) send_level(LEVEL_W'(levels[i]));
    wait_for_results();
  endtask

  task automatic test_coefficient_extremes();
    int frozen[]  = '{131071, -131072};
    int instant[] = '{65535, 0, 0, 40000};
    int held[]    = '{65535, 100, 0};
    // zero coefficients: the level stays put
    write_reg(REG_ATTACK, 0);
    write_reg(REG_DECAY, 0);
    settings_used++;
    foreach (frozen[i]) send_level(LEVEL_W'(frozen[i]));
    wait_for_results();
    // full coefficients, zero hold, peak wiped at once, zero threshold
    write_reg(REG_ATTACK, FULL_SCALE);
    write_reg(REG_DECAY, FULL_SCALE);
    write_reg(REG_PDECAY, 0);
    write_reg(REG_HOLD, 0);
    write_reg(REG_THRESH, 0);
    settings_used++;
    foreach (instant[i]) send_level(LEVEL_W'(instant[i]));
    wait_for_results();
    write_reg(REG_PDECAY, FULL_SCALE);
    write_reg(REG_HOLD, 255);
    write_reg(REG_THRESH, FULL_SCALE);
    settings_used++;
    foreach (held[i]) send_level(LEVEL_W'(held[i]));
    wait_for_results();
  endtask

  task automatic test_random_phases();
    int w;
    int v;
    int sent;
    int kind;
    int run;
    int base;
    int lvl;
    for (int phase = 0; phase < PHASES; phase++) begin
      wait_for_results();
      for (int i = 0; i < NUM_REGS; i++) begin
        w = (i == REG_HOLD) ? HOLD_W : VAL_W;
        if (phase == 0) v = (1 << w) - 1;
        else if (phase == 1) v = 0;
        else begin
          case ($urandom_range(0, 4))
            0:       v = 0;
            1:       v = (1 << w) - 1;
            default: v = $urandom_range(0, (1 << w) - 1);
          endcase
          // short holds and low thresholds make decay and redraw toggle often
          if (i == REG_HOLD && $urandom_range(0, 2) != 0) v = $urandom_range(0, 6);
          if (i == REG_THRESH && $urandom_range(0, 1) != 0) v = $urandom_range(0, 300);
        end
        write_reg(i, v);
      end
      write_reg($urandom_range(NUM_REGS, MAP_SLOTS - 1), $urandom());
      settings_used++;
      tx_gap_max   = (phase % 3 == 0) ? 0 : ((phase % 3 == 1) ? 3 : 12);
      rx_stall_max = (phase % 4 == 0) ? 0 : ((phase % 4 == 1) ? 12 : 3);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        run  = $urandom_range(1, 40);
        base = $urandom_range(0, FULL_SCALE);
        for (int k = 0; k < run && sent < PHASE_ITEMS; k++) begin
          case (kind)
            0, 1, 2: lvl = base;
            3, 4:    lvl = base + $urandom_range(0, 512) - 256;
            5:       lvl = (k * base) / run;
            6:       lvl = -$urandom_range(0, 131072);
            7:       lvl = $urandom_range(FULL_SCALE + 1, 131071);
            default: lvl = $urandom();
          endcase
          send_level(LEVEL_W'(lvl));
          sent++;
        end
      end
    end
  endtask

  // result side stalls in windows of its own
  always @(posedge clk) begin
    if (rx_count > 0) begin
      rx_count <= rx_count - 1;
    end else if (out_ready && rx_stall_max > 0) begin
      out_ready <= 1'b0;
      rx_count  <= $urandom_range(0, rx_stall_max - 1);
    end else begin
      out_ready <= 1'b1;
      rx_count  <= $urandom_range(1, 24);
    end
  end

  always @(posedge clk) begin : check_results
    lmb_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_ticks.size() == 0) begin
        $error("result transaction with no tick outstanding, shown_level %0d", out_shown_level);
        fail_count++;
      end else begin
        want = expected_ticks.pop_front();
        results_seen++;
        if (out_shown_level !== want.shown_level) begin
          $error("shown_level: expected %0d, got %0d", want.shown_level, out_shown_level);
          fail_count++;
        end
        if (out_peak_out !== want.peak_out) begin
          $error("peak_out: expected %0d, got %0d", want.peak_out, out_peak_out);
          fail_count++;
        end
        if (out_redraw !== want.redraw) begin
          $error("redraw: expected %0d, got %0d", want.redraw, out_redraw);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_psel && cfg_penable)) idle = 0;
      else idle++;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_register_access();
    test_input_extremes();
    test_coefficient_extremes();
    test_random_phases();
    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d meter ticks sent, %0d results checked, over %0d register settings",
             items_sent, results_seen, settings_used);
    $display("saturation at both rails, zero and full-scale coefficients, hold and decay");
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
